[rtl/ppt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the particle pool tick block
// Register addresses, sequencer states and the particle record layout.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_PERIOD   = 3'd0;
  localparam logic [2:0] REG_COLOR    = 3'd1;
  localparam logic [2:0] REG_POS_X    = 3'd2;
  localparam logic [2:0] REG_POS_Y    = 3'd3;
  localparam logic [2:0] REG_VEL_X    = 3'd4;
  localparam logic [2:0] REG_VEL_Y    = 3'd5;
  localparam logic [2:0] REG_LIFETIME = 3'd6;

  localparam logic signed [21:0] TIMER_MIN = -22'sd2097152;

  // one pool entry as stored in the particle memory
  typedef struct packed {
    logic [31:0]        color;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [21:0] life;
  } part_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIMER,
    ST_RD,
    ST_WAIT,
    ST_MULX,
    ST_MULY,
    ST_EMIT,
    ST_EMPTY,
    ST_CRD,
    ST_CWAIT,
    ST_CTAIL,
    ST_CTWAIT,
    ST_CWR
  } state_t;

  // datapath control from the sequencer
  typedef struct packed {
    logic       mul_sel_y;
    logic       mul_go;
  } mul_ctl_t;

endpackage

[rtl/ppt_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_step_unit: shared position step unit
// One registered multiply of velocity by delta_t, scaled to Q.8 with
// truncation toward zero, added to the selected position.
// ----------------------------------------------------------------------------
module ppt_step_unit
  import ppt_pkg::*;
(
  input  logic               clk,
  input  mul_ctl_t           ctl,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_y,
  input  logic [15:0]        dt,
  input  logic [31:0]        pos,
  output logic [31:0]        pos_new
);

  logic signed [23:0] vel;
  logic signed [40:0] prod;
  logic signed [40:0] prod_adj;

  // registered product of the selected velocity and delta_t
  assign vel = ctl.mul_sel_y ? vel_y : vel_x;

  always_ff @(posedge clk) begin
    if (ctl.mul_go) begin
      prod <= vel * $signed({1'b0, dt});
    end
  end

  // divide by 256 toward zero, then wrap the sum
  assign prod_adj = prod[40] ? (prod + 41'sd255) : prod;
  assign pos_new  = pos + prod_adj[39:8];

endmodule

[rtl/particle_pool_tick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_tick: particle pool advanced one tick per transaction
// Spawn timer, lifetime update, position step and compaction of the pool.
// ----------------------------------------------------------------------------
// A live particle takes read, memory wait, one multiply per axis and write
// back and report in the update pass, and one check in compaction; a dead
// one takes read and memory wait in the update pass and is replaced in
// compaction, where the tail particle is read and copied into its slot.
// When no particle is live, an empty report is sent before compaction. The
// single-port particle memory and the one shared multiplier set this
// sequence. Results leave through one output register, and the block
// takes no new tick until the last result of the current one is taken and
// compaction is done; output stalls lengthen the sequence.
module particle_pool_tick
  import ppt_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] delta_t,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  slot,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] color,
  output logic        valid_res,
  output logic        last
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);

  // configuration registers
  logic [19:0]        spawn_period;
  logic [31:0]        spawn_color;
  logic [31:0]        spawn_pos_x;
  logic [31:0]        spawn_pos_y;
  logic [23:0]        spawn_vel_x;
  logic [23:0]        spawn_vel_y;
  logic [19:0]        spawn_lifetime;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      spawn_period   <= 20'd16000;
      spawn_color    <= 32'hFFFF_FFFF;
      spawn_pos_x    <= '0;
      spawn_pos_y    <= '0;
      spawn_vel_x    <= '0;
      spawn_vel_y    <= '0;
      spawn_lifetime <= 20'd16000;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[ADDR_W-1:2])
        REG_PERIOD:   spawn_period   <= pwdata[19:0];
        REG_COLOR:    spawn_color    <= pwdata;
        REG_POS_X:    spawn_pos_x    <= pwdata;
        REG_POS_Y:    spawn_pos_y    <= pwdata;
        REG_VEL_X:    spawn_vel_x    <= pwdata[23:0];
        REG_VEL_Y:    spawn_vel_y    <= pwdata[23:0];
        REG_LIFETIME: spawn_lifetime <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_PERIOD:   prdata = {12'd0, spawn_period};
      REG_COLOR:    prdata = spawn_color;
      REG_POS_X:    prdata = spawn_pos_x;
      REG_POS_Y:    prdata = spawn_pos_y;
      REG_VEL_X:    prdata = {{8{spawn_vel_x[23]}}, spawn_vel_x};
      REG_VEL_Y:    prdata = {{8{spawn_vel_y[23]}}, spawn_vel_y};
      REG_LIFETIME: prdata = {12'd0, spawn_lifetime};
      default:      prdata = '0;
    endcase
  end

  // particle memory, one port, registered read
  part_t              mem [POOL_SIZE];
  part_t              rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_addr;
  part_t              mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // state
  state_t             state, state_next;
  logic signed [21:0] spawn_timer;
  logic [CNT_W-1:0]   active_count;
  logic [POOL_SIZE-1:0] dead_marks;
  logic [CNT_W-1:0]   idx;
  logic [15:0]        dt;
  logic               any_live;
  part_t              cur;
  part_t              tail;
  logic               ob_valid;
  logic               ob_load;

  // pending live result, held until the next one or the end of the pass
  logic             have_pend;
  logic [IDX_W-1:0] idx_last;
  logic [31:0]      last_px;
  logic [31:0]      last_py;
  logic [31:0]      last_col;

  // timer arithmetic
  logic signed [22:0] timer_sub;
  logic signed [21:0] timer_sat;
  assign timer_sub = {spawn_timer[21], spawn_timer} - $signed({7'd0, dt});
  assign timer_sat = (timer_sub < 23'(TIMER_MIN)) ? TIMER_MIN : timer_sub[21:0];

  // shared step unit
  mul_ctl_t     mctl;
  logic [31:0]  step_pos;
  logic [31:0]  pos_new;
  assign step_pos = (state == ST_EMIT) ? cur.pos_y : cur.pos_x;

  ppt_step_unit u_step (
    .clk     (clk),
    .ctl     (mctl),
    .vel_x   (cur.vel_x),
    .vel_y   (cur.vel_y),
    .dt      (dt),
    .pos     (step_pos),
    .pos_new (pos_new)
  );

  logic signed [22:0] life_new;
  part_t              rd_upd;
  assign life_new = {rd_data.life[21], rd_data.life} - $signed({7'd0, dt});

  // entry just read with its lifetime aged
  always_comb begin
    rd_upd      = rd_data;
    rd_upd.life = life_new[21:0];
  end

  logic out_free;
  assign out_free = !ob_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || ob_valid;
  assign out_valid = ob_valid;

  // output register loads
  assign ob_load = out_free && ((state == ST_RD && idx >= active_count && any_live) ||
                                (state == ST_EMIT && have_pend) || (state == ST_EMPTY));

  // next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = idx[IDX_W-1:0];
    mem_wdata  = cur;
    mctl       = '0;
    case (state)
      ST_IDLE:   if (in_valid && !ob_valid) state_next = ST_TIMER;
      ST_TIMER: begin
        // spawn into the tail slot
        if (timer_sat <= 0 && active_count < CNT_W'(POOL_SIZE)) begin
          mem_we    = 1'b1;
          mem_addr  = active_count[IDX_W-1:0];
          mem_wdata = '{color: spawn_color, pos_x: spawn_pos_x, pos_y: spawn_pos_y,
                        vel_x: spawn_vel_x, vel_y: spawn_vel_y,
                        life: {2'b00, spawn_lifetime}};
        end
        state_next = ST_RD;
      end
      ST_RD: begin
        if (idx < active_count) state_next = ST_WAIT;
        else if (!any_live) state_next = ST_EMPTY;
        else if (out_free) state_next = ST_CRD;
      end
      ST_WAIT: begin
        if (life_new <= 0) state_next = ST_RD;
        else state_next = ST_MULX;
      end
      ST_MULX: begin
        mctl.mul_go = 1'b1;
        state_next  = ST_MULY;
      end
      ST_MULY: begin
        mctl.mul_sel_y = 1'b1;
        mctl.mul_go    = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          mem_we          = 1'b1;
          mem_addr        = IDX_W'(idx - 1'b1);
          mem_wdata.pos_y = pos_new;
          state_next      = ST_RD;
        end
      end
      ST_EMPTY:  if (out_free) state_next = ST_CRD;
      ST_CRD: begin
        if (idx == '0) state_next = ST_IDLE;
        else if (dead_marks[IDX_W'(idx - 1'b1)]) begin
          mem_addr   = IDX_W'(active_count - 1'b1);
          state_next = ST_CTWAIT;
        end
      end
      ST_CTWAIT: begin
        mem_addr   = IDX_W'(active_count - 1'b1);
        state_next = ST_CTAIL;
      end
      ST_CTAIL:  state_next = ST_CWR;
      ST_CWR: begin
        mem_we     = 1'b1;
        mem_addr   = IDX_W'(idx - 1'b1);
        mem_wdata  = tail;
        state_next = ST_CRD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      spawn_timer  <= '0;
      active_count <= '0;
      dead_marks   <= '0;
      idx          <= '0;
      ob_valid     <= 1'b0;
      any_live     <= 1'b0;
      have_pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (ob_load) ob_valid <= 1'b1;
      else if (!out_stall) ob_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          dt       <= delta_t;
          idx      <= '0;
          any_live <= 1'b0;
        end
        ST_TIMER: begin
          if (timer_sat <= 0) begin
            spawn_timer <= timer_sat + $signed({2'b00, spawn_period});
            if (active_count < CNT_W'(POOL_SIZE)) active_count <= active_count + 1'b1;
          end else begin
            spawn_timer <= timer_sat;
          end
        end
        ST_RD: begin
          if (idx < active_count) idx <= idx + 1'b1;
          else if (any_live && out_free) begin
            // flag the final reported particle
            idx       <= active_count;
            slot      <= 6'(idx_last);
            pos_x     <= last_px;
            pos_y     <= last_py;
            color     <= last_col;
            valid_res <= 1'b1;
            last      <= 1'b1;
            have_pend <= 1'b0;
          end
        end
        ST_WAIT: begin
          cur <= rd_upd;
          if (life_new <= 0) dead_marks[IDX_W'(idx - 1'b1)] <= 1'b1;
        end
        ST_MULY:   cur.pos_x <= pos_new;
        ST_EMIT: begin
          if (out_free) begin
            cur.pos_y <= pos_new;
            // hold the newest live particle back so last can be set on it
            if (have_pend) begin
              slot      <= 6'(idx_last);
              pos_x     <= last_px;
              pos_y     <= last_py;
              color     <= last_col;
              valid_res <= 1'b1;
              last      <= 1'b0;
            end
            have_pend <= 1'b1;
            idx_last  <= IDX_W'(idx - 1'b1);
            last_px   <= cur.pos_x;
            last_py   <= pos_new;
            last_col  <= cur.color;
            any_live  <= 1'b1;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            slot      <= '0;
            pos_x     <= '0;
            pos_y     <= '0;
            color     <= '0;
            valid_res <= 1'b0;
            last      <= 1'b1;
            idx       <= active_count;
          end
        end
        ST_CRD: begin
          if (idx != '0 && !dead_marks[IDX_W'(idx - 1'b1)]) idx <= idx - 1'b1;
        end
        ST_CTAIL:  tail <= rd_data;
        ST_CWR: begin
          dead_marks[IDX_W'(idx - 1'b1)] <= 1'b0;
          active_count <= active_count - 1'b1;
          idx          <= idx - 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/ppt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_checker: port-level checks of the particle pool tick block
// Watches the result channel and the tick handshake.
// ----------------------------------------------------------------------------
module ppt_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] pos_x,
  input logic        valid_res,
  input logic        last,
  input logic        pready
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(last))
    else $error("stalled result changed");

  // an empty report is always the final one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> last)
    else $error("empty result without last");

  // a tick is accepted only when no result is pending
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid)
    else $error("tick accepted while result pending");

  // the register port never waits
  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind particle_pool_tick ppt_port_checks u_ppt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pos_x     (pos_x),
  .valid_res (valid_res),
  .last      (last),
  .pready    (pready)
);
